FILE: rtl/rc_frame_decode_failsafe_top_macros.svh
// Assertion macros for the remote-control frame decoder checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef RC_FRAME_DECODE_FAILSAFE_TOP_MACROS_SVH
`define RC_FRAME_DECODE_FAILSAFE_TOP_MACROS_SVH

// Same-cycle implication
`define RCFD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcfd assertion failed");

// Next-cycle implication
`define RCFD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcfd assertion failed");

`endif

FILE: rtl/rcfd_pkg.sv
// Shared types and constants of the remote-control frame decoder.
// No dependencies.
`default_nettype none

package rcfd_pkg;

    localparam int ChanW    = 11;
    localparam int SwW      = 2;
    localparam int CountW   = 16;
    localparam int FrameW   = 128;
    localparam int OutDataW = 136;
    localparam int CfgDataW = 16;

    localparam logic [ChanW-1:0]  CENTER_RST  = 11'h400;
    localparam logic [CountW-1:0] LIMIT_RST   = 16'd100;
    localparam logic [SwW-1:0]    SW_UP_RST   = 2'd1;
    localparam logic [SwW-1:0]    SW_MID_RST  = 2'd3;
    localparam logic [SwW-1:0]    SW_INVALID  = 2'd0;
    localparam logic [CountW:0]   ALIVE_STEP  = 17'd2;

    typedef enum logic [1:0] {
        CFG_CENTER = 2'd0,
        CFG_LIMIT  = 2'd1,
        CFG_SW_UP  = 2'd2,
        CFG_SW_MID = 2'd3
    } cfg_index_t;

    typedef enum logic {
        REQ_FRAME = 1'b0,
        REQ_TICK  = 1'b1
    } req_type_t;

    typedef struct packed {
        logic [15:0]            keys;
        logic [15:0]            buttons;
        logic [47:0]            mouse;
        logic [SwW-1:0]         right_sw;
        logic [SwW-1:0]         left_sw;
        logic [3:0][ChanW-1:0]  stick;
    } rc_data_t;

    function automatic rc_data_t failsafe_data(
        input logic [ChanW-1:0] center,
        input logic [SwW-1:0]   left_code,
        input logic [SwW-1:0]   right_code
    );
        rc_data_t d;
        d.keys     = '0;
        d.buttons  = '0;
        d.mouse    = '0;
        d.right_sw = right_code;
        d.left_sw  = left_code;
        d.stick    = {4{center}};
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rcfd_unpack.sv
// Slices a 16-byte frame into stick, switch, mouse and key fields.
// Depends on rcfd_pkg.
`default_nettype none

module rcfd_unpack (
    input  wire logic [rcfd_pkg::FrameW-1:0] frame,
    output rcfd_pkg::rc_data_t               data,
    output logic                             bad_switch
);
    import rcfd_pkg::*;

    always_comb
    begin
        data.stick[0] = frame[10:0];
        data.stick[1] = frame[21:11];
        data.stick[2] = frame[32:22];
        data.stick[3] = frame[43:33];
        data.right_sw = frame[45:44];
        data.left_sw  = frame[47:46];
        data.mouse    = frame[95:48];
        data.buttons  = frame[111:96];
        data.keys     = frame[127:112];
        bad_switch    = (frame[47:46] == SW_INVALID);
    end

endmodule

`default_nettype wire

FILE: rtl/rc_frame_decode_failsafe_top.sv
// An accepted transaction's result appears on the master side in the next cycle. Throughput:
// one transaction per cycle unless stalled; held state and result register update together.
// Reset: asynchronous, active low; all but out_data_reg take defaults, held data returns
// to failsafe defaults with the left switch at the up code, link offline, no result pending.
// Top level of the remote-control frame decoder. Depends on rcfd_pkg and rcfd_unpack.
`default_nettype none

module rc_frame_decode_failsafe_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // frame_low [63:0], frame_high [127:64]
    input  wire logic [rcfd_pkg::FrameW-1:0]   s_axis_tdata,
    // req_type [0]
    input  wire logic                          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // stick_ch0 [10:0], stick_ch1 [21:11], stick_ch2 [32:22], stick_ch3 [43:33],
    // left_switch [45:44], right_switch [47:46], mouse_axes [95:48],
    // mouse_buttons [111:96], key_mask [127:112], link_online [128],
    // frame_fault [129], zero [135:130]
    output logic [rcfd_pkg::OutDataW-1:0]      m_axis_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [rcfd_pkg::CfgDataW-1:0] cfg_data
);
    import rcfd_pkg::*;

    logic [ChanW-1:0]    center_reg;
    logic [CountW-1:0]   limit_reg;
    logic [SwW-1:0]      sw_up_reg;
    logic [SwW-1:0]      sw_mid_reg;

    rc_data_t            data_reg, data_next;
    logic [CountW-1:0]   alive_reg, alive_next;
    logic                fresh_reg, fresh_next;
    logic                online_reg, online_next;
    logic                fault_next;
    logic                out_valid_reg, out_valid_next;
    logic [OutDataW-1:0] out_data_reg, out_data_next;

    rc_data_t            frame_data;
    logic                bad_switch;
    logic                accept;
    logic [CountW:0]     alive_sum;

    rcfd_unpack u_unpack (
        .frame      (s_axis_tdata),
        .data       (frame_data),
        .bad_switch (bad_switch)
    );

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign alive_sum     = {1'b0, alive_reg} + ALIVE_STEP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= CENTER_RST;
            limit_reg  <= LIMIT_RST;
            sw_up_reg  <= SW_UP_RST;
            sw_mid_reg <= SW_MID_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CENTER: center_reg <= cfg_data[ChanW-1:0];
                CFG_LIMIT:  limit_reg  <= cfg_data[CountW-1:0];
                CFG_SW_UP:  sw_up_reg  <= cfg_data[SwW-1:0];
                CFG_SW_MID: sw_mid_reg <= cfg_data[SwW-1:0];
                default:    center_reg <= center_reg;
            endcase
        end
    end

    always_comb
    begin
        data_next   = data_reg;
        alive_next  = alive_reg;
        fresh_next  = fresh_reg;
        online_next = online_reg;
        fault_next  = 1'b0;
        if (accept)
        begin
            unique case (req_type_t'(s_axis_tuser))
                REQ_FRAME:
                begin
                    if (bad_switch)
                    begin
                        fault_next = 1'b1;
                    end
                    else
                    begin
                        data_next  = frame_data;
                        fresh_next = 1'b1;
                    end
                end
                REQ_TICK:
                begin
                    if (fresh_reg)
                    begin
                        alive_next  = '0;
                        online_next = 1'b1;
                        fresh_next  = 1'b0;
                    end
                    else if (alive_sum >= {1'b0, limit_reg})
                    begin
                        data_next   = failsafe_data(center_reg, sw_mid_reg, sw_mid_reg);
                        alive_next  = limit_reg;
                        online_next = 1'b0;
                    end
                    else
                    begin
                        alive_next = alive_sum[CountW-1:0];
                    end
                end
                default:
                begin
                    fault_next = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = accept || (out_valid_reg && !m_axis_tready);
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_data_next = {6'b0, fault_next, online_next,
                             data_next.keys, data_next.buttons, data_next.mouse,
                             data_next.right_sw, data_next.left_sw,
                             data_next.stick[3], data_next.stick[2],
                             data_next.stick[1], data_next.stick[0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg      <= failsafe_data(CENTER_RST, SW_UP_RST, SW_MID_RST);
            alive_reg     <= '0;
            fresh_reg     <= 1'b0;
            online_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            data_reg      <= data_next;
            alive_reg     <= alive_next;
            fresh_reg     <= fresh_next;
            online_reg    <= online_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

FILE: rtl/rcfd_checker.sv
// Port-level assertions for the remote-control frame decoder, bound to the top level.
// Depends on rcfd_pkg and rc_frame_decode_failsafe_top_macros.svh.
`default_nettype none

`include "rc_frame_decode_failsafe_top_macros.svh"

module rcfd_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic [rcfd_pkg::FrameW-1:0]   s_axis_tdata,
    input  wire logic                          s_axis_tuser,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [rcfd_pkg::OutDataW-1:0] m_axis_tdata
);
    import rcfd_pkg::*;

    logic in_xact;
    logic out_stall;

    assign in_xact   = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;

    `RCFD_ASSERT_NEXT(a_result_follows, in_xact, m_axis_tvalid)
    `RCFD_ASSERT_NEXT(a_bad_frame_faults,
        in_xact && (s_axis_tuser == REQ_FRAME) && (s_axis_tdata[47:46] == SW_INVALID),
        m_axis_tdata[129])
    `RCFD_ASSERT_NEXT(a_tick_no_fault, in_xact && (s_axis_tuser == REQ_TICK),
        !m_axis_tdata[129])
    `RCFD_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)
    `RCFD_ASSERT_NEXT(a_stall_holds, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind rc_frame_decode_failsafe_top rcfd_checker u_rcfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
